// File: sv/wgm_pkg.sv
package wgm_pkg;

    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;

    localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_CHAR  = 8'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 2'd0,
        REG_PATTERN_LOW    = 2'd1,
        REG_PATTERN_HIGH   = 2'd2
    } cfg_reg_t;

    // Per-position control into one cell
    typedef struct packed {
        logic live;      // position live before star closure
        logic in_range;  // position <= used length
        logic in_use;    // position <  used length (has a pattern char)
    } cell_ctl_t;

    // Per-position result out of one cell
    typedef struct packed {
        logic hold;  // closed position sits on a star: stays live, closes into next
        logic step;  // closed position consumes the byte: next position goes live
    } cell_out_t;

endpackage

// File: sv/wgm_if.sv
interface wgm_text_if;
    import wgm_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              has_byte;
    logic              end_of_text;

    modport source (output valid, output text_byte, output has_byte, output end_of_text,
                    input ready);
    modport sink   (input valid, input text_byte, input has_byte, input end_of_text,
                    output ready);
endinterface

interface wgm_result_if;
    logic valid;
    logic ready;
    logic matches_res;
    logic final_res;

    modport source (output valid, output matches_res, output final_res, input ready);
    modport sink   (input valid, input matches_res, input final_res, output ready);
endinterface

interface wgm_cfg_if;
    import wgm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/wgm_cell.sv
module wgm_cell (
    input  wgm_pkg::cell_ctl_t         ctl,
    input  logic [wgm_pkg::BYTE_W-1:0] pat_char,
    input  logic [wgm_pkg::BYTE_W-1:0] text_byte,
    input  logic                       carry_in,
    output wgm_pkg::cell_out_t         res
);
    import wgm_pkg::*;

    logic closed;
    logic is_star;
    logic hit;

    assign closed  = (ctl.live & ctl.in_range) | carry_in;
    assign is_star = (pat_char == STAR_CHAR);
    assign hit     = (pat_char == ANY_CHAR) || (pat_char == text_byte);

    assign res.hold = closed & ctl.in_use & is_star;
    assign res.step = closed & ctl.in_use & ~is_star & hit;

endmodule

// File: sv/wildcard_glob_matcher_top.sv
// Wildcard glob matcher: '*' matches any run of bytes, '?' matches one byte,
// any other pattern byte matches itself.
//
// Channels:
//   cfg    - register writes (index 0: pattern length, 1: pattern bytes 0..7,
//            2: pattern bytes 8..15). Always ready; write only while idle.
//   text   - one text word per cycle while ready is high: text_byte, has_byte, end_of_text.
//   result - one word per text word: matches_res tells whether the text so
//            far matches the whole pattern, final_res echoes end_of_text.
//
// Throughput is one word per cycle unless the receiver stalls. Each result word
// is registered and shows in the cycle after its text word is taken. A row of
// PATTERN_MAX cells works on the live pattern positions; each cell closes stars
// into its right neighbor and advances its position on the byte, all in the
// accepting cycle. The result register recloses the new vector on the output
// side. A word with end_of_text restarts the matcher for the next text.
//
// When the receiver stalls, the result word holds and text is still taken if
// the pending result leaves this cycle. Reset clears all registers, leaves
// only the pattern start position live and drops any pending result.
module wildcard_glob_matcher_top #(
    parameter int PATTERN_MAX = 16
) (
    input logic          clk,
    input logic          rst_n,
    wgm_cfg_if.sink      cfg,
    wgm_text_if.sink     text,
    wgm_result_if.source result
);
    import wgm_pkg::*;

    localparam int VEC_W = PATTERN_MAX + 1;

    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] pat_low_reg;
    logic [WORD_W-1:0] pat_high_reg;
    logic [VEC_W-1:0]  live_reg;
    logic [VEC_W-1:0]  live_next;
    logic [VEC_W-1:0]  res_vec_reg;
    logic              res_last_reg;
    logic              res_valid_reg;

    logic [LEN_W-1:0]        len_used;
    logic [2*WORD_W-1:0]     pat_all;
    logic                    text_acc;
    logic [PATTERN_MAX-1:0]  carry;
    cell_out_t               cres [PATTERN_MAX];
    logic [VEC_W-1:0]        adv;
    logic [VEC_W-1:0]        oc;
    logic [VEC_W-1:0]        pick;

    assign len_used = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;
    assign pat_all  = {pat_high_reg, pat_low_reg};

    assign cfg.ready  = 1'b1;
    assign text.ready = ~res_valid_reg | result.ready;
    assign text_acc   = text.valid & text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_PATTERN_LENGTH: len_reg      <= cfg.data[LEN_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= cfg.data;
                REG_PATTERN_HIGH:   pat_high_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    // Row of cells: star closure ripples left to right through carry
    assign carry[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < PATTERN_MAX; i++)
        begin : g_cell
            cell_ctl_t ctl;
            assign ctl.live     = live_reg[i];
            assign ctl.in_range = (LEN_W'(i) <= len_used);
            assign ctl.in_use   = (LEN_W'(i) < len_used);

            wgm_cell u_cell (
                .ctl       (ctl),
                .pat_char  (pat_all[BYTE_W*i +: BYTE_W]),
                .text_byte (text.text_byte),
                .carry_in  (carry[i]),
                .res       (cres[i])
            );

            if (i < PATTERN_MAX - 1)
            begin : g_carry
                assign carry[i+1] = cres[i].hold;
            end

            if (i == 0)
            begin : g_first
                assign adv[i] = cres[i].hold;
            end
            else
            begin : g_rest
                assign adv[i] = cres[i].hold | cres[i-1].step;
            end
        end
    endgenerate

    assign adv[PATTERN_MAX] = cres[PATTERN_MAX-1].step;

    always_comb
    begin
        live_next = live_reg;
        if (text_acc)
        begin
            if (text.end_of_text)
                live_next = VEC_W'(1);
            else if (text.has_byte)
                live_next = adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg      <= VEC_W'(1);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            live_reg <= live_next;
            if (text_acc)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Result payload: vector after this word's byte, before end-of-text restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vec_reg  <= '0;
            res_last_reg <= 1'b0;
        end
        else if (text_acc)
        begin
            res_vec_reg  <= text.has_byte ? adv : live_reg;
            res_last_reg <= text.end_of_text;
        end
    end

    // Output-side star closure; user must keep pattern stable while a result is pending; not enforced
    generate
        for (i = 0; i < VEC_W; i++)
        begin : g_close
            if (i == 0)
            begin : g_first
                assign oc[i] = res_vec_reg[i];
            end
            else
            begin : g_rest
                assign oc[i] = (res_vec_reg[i] & (LEN_W'(i) <= len_used))
                             | (oc[i-1] & (LEN_W'(i-1) < len_used)
                                & (pat_all[BYTE_W*(i-1) +: BYTE_W] == STAR_CHAR));
            end
            assign pick[i] = oc[i] & (len_used == LEN_W'(i));
        end
    endgenerate

    assign result.valid       = res_valid_reg;
    assign result.matches_res = |pick;
    assign result.final_res   = res_last_reg;

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        text_acc && text.end_of_text |=> live_reg == VEC_W'(1))
        else $error("matcher not restarted after end of text");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        text_acc |=> res_valid_reg)
        else $error("accepted word produced no result");

    a_empty_word_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        text_acc && !text.has_byte && !text.end_of_text |=> $stable(live_reg))
        else $error("word without byte changed live positions");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result.ready |=> $stable(res_vec_reg) && $stable(res_last_reg))
        else $error("pending result changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result.ready |-> !text_acc)
        else $error("word taken while result register full");

endmodule

// File: dv/tb_top.sv
module tb_top;
    import wgm_pkg::*;

    localparam int PAT_MAX     = 16;
    localparam int WORD_TARGET = 1800;
    localparam int PHASE_WORDS = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 50;

    typedef logic [BYTE_W-1:0] text_q_t[$];

    typedef struct packed {
        logic hit;
        logic eot;
    } match_word_t;

    logic clk = 1'b0;
    logic rst_n;

    wgm_cfg_if    cfg_ch ();
    wgm_text_if   text_ch ();
    wgm_result_if result_ch ();

    wildcard_glob_matcher_top #(
        .PATTERN_MAX(PAT_MAX)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .text  (text_ch),
        .result(result_ch)
    );

    // Shadow of the matcher: registers and live position vector
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] pat_lo;
    logic [WORD_W-1:0] pat_hi;
    logic [PAT_MAX:0]  live_vec;
    match_word_t       expected_matches[$];

    int  err_count   = 0;
    int  words_sent  = 0;
    int  texts_sent  = 0;
    int  loads_done  = 0;
    int  hits_seen   = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  quiet_sender = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_error(string msg);
        if (err_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    function automatic int used_len();
        return (len_reg > PAT_MAX) ? PAT_MAX : int'(len_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] pat_at(int i);
        if (i < 8)
            return pat_lo[i*8 +: 8];
        return pat_hi[(i-8)*8 +: 8];
    endfunction

    function automatic logic [PAT_MAX:0] close_stars(logic [PAT_MAX:0] v);
        int n;
        n = used_len();
        for (int i = 0; i <= PAT_MAX; i++)
            if (i > n)
                v[i] = 1'b0;
        // a live star also opens the position behind it, chaining through runs
        for (int i = 0; i < n; i++)
            if (v[i] && pat_at(i) == STAR_CHAR)
                v[i+1] = 1'b1;
        return v;
    endfunction

    function automatic logic [PAT_MAX:0] consume_byte(logic [PAT_MAX:0] v,
                                                      logic [BYTE_W-1:0] c);
        logic [PAT_MAX:0] closed;
        logic [PAT_MAX:0] nxt;
        int n;
        n      = used_len();
        closed = close_stars(v);
        nxt    = '0;
        for (int i = 0; i < n; i++)
        begin
            if (closed[i])
            begin
                if (pat_at(i) == STAR_CHAR)
                    nxt[i] = 1'b1;
                else if (pat_at(i) == ANY_CHAR || pat_at(i) == c)
                    nxt[i+1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    function automatic void predict_word(logic [BYTE_W-1:0] b, logic has, logic eot);
        logic [PAT_MAX:0] closed;
        match_word_t w;
        if (has)
            live_vec = consume_byte(live_vec, b);
        closed = close_stars(live_vec);
        w.hit  = closed[used_len()];
        w.eot  = eot;
        expected_matches.push_back(w);
        if (eot)
            live_vec = 1;
    endfunction

    // Receiver: ready pattern switches at random between four modes
    initial
    begin
        int stall_mode;
        int stall_left;
        int tick;
        stall_mode = 0;
        stall_left = 0;
        tick       = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            tick++;
            case (stall_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= 1'($urandom_range(0, 1));
                2:       result_ch.ready <= (tick % 3 != 0);
                default: result_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        match_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_matches.size() == 0)
                report_error("result word with nothing expected");
            else
            begin
                want = expected_matches.pop_front();
                if (result_ch.matches_res !== want.hit)
                    report_error($sformatf("matches_res got %b want %b",
                                           result_ch.matches_res, want.hit));
                if (result_ch.final_res !== want.eot)
                    report_error($sformatf("final_res got %b want %b",
                                           result_ch.final_res, want.eot));
                if (result_ch.matches_res === 1'b1)
                    hits_seen++;
            end
        end
    end

    task automatic send_word(logic [BYTE_W-1:0] b, logic has, logic eot);
        int gap;
        if (burst_left == 0)
        begin
            gap = (quiet_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.has_byte    <= has;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        predict_word(b, has, eot);
        words_sent++;
    endtask

    // Drop valid and hold until every result word is back
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
            REG_PATTERN_LOW:    pat_lo  = data;
            REG_PATTERN_HIGH:   pat_hi  = data;
            default: ;
        endcase
    endtask

    task automatic load_pattern(logic [2*WORD_W-1:0] p, logic [WORD_W-1:0] len_word);
        write_reg(REG_PATTERN_LOW, p[WORD_W-1:0]);
        write_reg(REG_PATTERN_HIGH, p[2*WORD_W-1:WORD_W]);
        write_reg(REG_PATTERN_LENGTH, len_word);
        cfg_ch.valid <= 1'b0;
        loads_done++;
    endtask

    task automatic send_text(text_q_t t, bit close, bit noisy);
        bit trailer;
        trailer = noisy && ($urandom_range(0, 5) == 0);
        for (int i = 0; i < t.size(); i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(t[i], 1'b1, close && !trailer && (i == t.size() - 1));
        end
        // close with a characterless word when the text is empty or asked to
        if (close && (trailer || t.size() == 0))
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        if (close)
            texts_sent++;
    endtask

    function automatic logic [2*WORD_W-1:0] pack_str(string s);
        logic [2*WORD_W-1:0] p;
        p = '0;
        for (int i = 0; i < s.len() && i < PAT_MAX; i++)
            p[i*8 +: 8] = s[i];
        return p;
    endfunction

    function automatic text_q_t str_bytes(string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [BYTE_W-1:0] text_char();
        case ($urandom_range(0, 7))
            0, 1:    return "a";
            2:       return "b";
            3:       return "c";
            4:       return STAR_CHAR;
            5:       return ANY_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] glob_char();
        case ($urandom_range(0, 9))
            0, 1:    return STAR_CHAR;
            2, 3:    return ANY_CHAR;
            4, 5:    return "a";
            6:       return "b";
            7:       return "c";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Expand the first n pattern characters into a text that should match
    function automatic text_q_t matching_text(logic [2*WORD_W-1:0] p, int n);
        text_q_t q;
        logic [BYTE_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = p[i*8 +: 8];
            if (c == STAR_CHAR)
                repeat ($urandom_range(0, 3)) q.push_back(text_char());
            else if (c == ANY_CHAR)
                q.push_back(text_char());
            else
                q.push_back(c);
        end
        return q;
    endfunction

    function automatic text_q_t mutate(text_q_t q);
        int k;
        case ($urandom_range(0, 2))
            0:
            begin
                if (q.size() > 0)
                begin
                    k    = $urandom_range(0, q.size() - 1);
                    q[k] = text_char();
                end
            end
            1:
            begin
                if (q.size() > 0)
                begin
                    k = $urandom_range(0, q.size() - 1);
                    q.delete(k);
                end
            end
            default:
            begin
                k = $urandom_range(0, q.size());
                q.insert(k, text_char());
            end
        endcase
        return q;
    endfunction

    // Straight after reset the pattern is empty: only an empty text matches
    task automatic test_reset_state();
        text_q_t none;
        send_text(none, 1'b1, 1'b0);
        send_text(str_bytes("a"), 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
    endtask

    task automatic test_literal_extremes();
        text_q_t t;
        wait_drained();
        load_pattern({112'h0, 8'hFF, 8'h00}, 64'd2);
        t = '{8'h00, 8'hFF};
        send_text(t, 1'b1, 1'b0);
        t = '{8'hFF};
        send_text(t, 1'b1, 1'b0);
    endtask

    task automatic test_wildcards();
        text_q_t none;
        wait_drained();
        load_pattern(pack_str("a*b?"), 64'd4);
        send_text(str_bytes("abz"), 1'b1, 1'b0);
        send_text(str_bytes("ab"), 1'b1, 1'b0);
        wait_drained();
        load_pattern(pack_str("*?"), 64'd2);
        send_text(none, 1'b1, 1'b0);
        send_text(str_bytes("q"), 1'b1, 1'b0);
    endtask

    // Length 31 must act as the full sixteen characters
    task automatic test_oversized_length();
        text_q_t none;
        wait_drained();
        load_pattern(pack_str("***************?"), {$urandom, 27'($urandom), 5'd31});
        send_text(str_bytes("x"), 1'b1, 1'b0);
        send_text(none, 1'b1, 1'b0);
    endtask

    // Reload the pattern between two words of one text
    task automatic test_midtext_change();
        wait_drained();
        load_pattern(pack_str("ab"), 64'd2);
        send_text(str_bytes("a"), 1'b0, 1'b0);
        wait_drained();
        load_pattern(pack_str("a*"), 64'd2);
        send_text(str_bytes("q"), 1'b1, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [2*WORD_W-1:0] p;
        logic [WORD_W-1:0]   len_word;
        text_q_t t;
        int n;
        int start;
        while (words_sent < WORD_TARGET)
        begin
            wait_drained();
            for (int i = 0; i < PAT_MAX; i++)
                p[i*8 +: 8] = glob_char();
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = PAT_MAX;
                2:       n = $urandom_range(PAT_MAX + 1, 31);
                default: n = $urandom_range(1, 8);
            endcase
            len_word = {$urandom, $urandom};
            len_word[LEN_W-1:0] = n[LEN_W-1:0];
            if ($urandom_range(0, 1) == 0)
                len_word[WORD_W-1:LEN_W] = '0;
            load_pattern(p, len_word);
            quiet_sender = ($urandom_range(0, 3) == 0);
            if (n > PAT_MAX)
                n = PAT_MAX;
            start = words_sent;
            while (words_sent - start < PHASE_WORDS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    t = matching_text(p, n);
                    if ($urandom_range(0, 9) < 3)
                        t = mutate(t);
                end
                else
                begin
                    t.delete();
                    repeat ($urandom_range(0, 8)) t.push_back(text_char());
                end
                send_text(t, 1'b1, 1'b1);
            end
            // leave a text open now and then so the next load lands mid-text
            if ($urandom_range(0, 3) == 0)
                send_text(matching_text(p, n / 2), 1'b0, 1'b1);
        end
        quiet_sender = 1'b0;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_PATTERN_LENGTH;
        cfg_ch.data         <= '0;
        text_ch.valid       <= 1'b0;
        text_ch.text_byte   <= '0;
        text_ch.has_byte    <= 1'b0;
        text_ch.end_of_text <= 1'b0;
        len_reg  = '0;
        pat_lo   = '0;
        pat_hi   = '0;
        live_vec = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_literal_extremes();
        test_wildcards();
        test_oversized_length();
        test_midtext_change();
        test_random_phases();
        wait_drained();

        $display("Run covered %0d text words in %0d closed texts over %0d pattern loads.",
                 words_sent, texts_sent, loads_done);
        $display("Result side saw %0d matching words; %0d errors logged.",
                 hits_seen, err_count);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: wildcard_glob_matcher_top.f
sv/wgm_pkg.sv
sv/wgm_if.sv
sv/wgm_cell.sv
sv/wildcard_glob_matcher_top.sv
dv/tb_top.sv
